// File: sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes of the sorted priority queue
// Item and result layouts, the key of one entry, cell control and status codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spq_pkg;

	localparam int TAG_W = 16;
	localparam int KEY_W = 8;
	localparam int OCC_W = 5;

	// Operation codes.
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Result status codes.
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_DUP     = 3'd1;
	localparam logic [2:0] ST_IGNORED = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_EMPTY   = 3'd4;

	typedef struct packed {
		logic             operation;
		logic [TAG_W-1:0] patient_tag;
		logic [KEY_W-1:0] age;
		logic [KEY_W-1:0] severity;
	} spq_cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             head_valid;
		logic [TAG_W-1:0] head_tag;
		logic [KEY_W-1:0] head_age;
		logic [KEY_W-1:0] head_severity;
		logic [OCC_W-1:0] occupancy;
		logic             dup_seen;
		logic [TAG_W-1:0] dup_stored_tag;
		logic [TAG_W-1:0] dup_new_tag;
		logic [KEY_W-1:0] dup_severity;
	} spq_result_t;

	// Ordering key of one stored entry.
	typedef struct packed {
		logic [KEY_W-1:0] sev;
		logic [KEY_W-1:0] age;
	} spq_key_t;

	// Commit strobes broadcast to every cell.
	typedef struct packed {
		logic ins;
		logic pop;
	} spq_ctrl_t;

endpackage

// File: sv/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Compares its entry with the incoming key, then keeps its entry, takes the
// new entry, takes its left neighbour's entry on insert or its right
// neighbour's entry on pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
#(
	parameter int TW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          eval,
	input  spq_key_t      key,
	input  logic          occ,
	input  spq_ctrl_t     ctrl,
	input  spq_key_t      new_key,
	input  logic [TW-1:0] new_tag,
	input  logic          prev_ahead,
	input  spq_key_t      left_key,
	input  logic [TW-1:0] left_tag,
	input  spq_key_t      right_key,
	input  logic [TW-1:0] right_tag,
	output spq_key_t      key_q,
	output logic [TW-1:0] tag_q,
	output logic          ahead_q,
	output logic          match_q
);

	logic ahead_d;
	logic match_d;

	// An occupied entry stays ahead of a new one with a larger severity, or
	// with the same severity and a smaller age.
	always_comb begin
		if (key_q.sev != key.sev) begin
			ahead_d = occ && (key_q.sev < key.sev);
		end else begin
			ahead_d = occ && (key_q.age > key.age);
		end
		match_d = occ && (key_q.sev == key.sev) && (key_q.age == key.age);
	end

	// Compare results are captured when an item is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ahead_q <= 1'b0;
			match_q <= 1'b0;
		end else if (eval) begin
			ahead_q <= ahead_d;
			match_q <= match_d;
		end
	end

	// Entry update: shift right on insert behind the insertion point,
	// shift left on pop.
	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (ctrl.ins && !ahead_q) begin
			if (prev_ahead) begin
				key_q <= new_key;
				tag_q <= new_tag;
			end else begin
				key_q <= left_key;
				tag_q <= left_tag;
			end
		end
	end

endmodule

// File: sv/sorted_priority_queue_dup_detect.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue_dup_detect: sorted priority queue with duplicate trap
// A row of DEPTH cells kept in ascending severity, descending age; a push of
// an existing key latches a sticky duplicate record and blocks later pushes.
// ----------------------------------------------------------------------------
// Flow: an accepted item is held in the first stage (v_s1) while the cells
// compare, then commits and raises its result strobe; busy is high meanwhile.
// A new item is taken only once the last one has left the first stage: the
// compare in every cell is followed by the commit that needs the row's match flag.
// Reset: asynchronous, empties the queue and clears the duplicate record.
// The receiver cannot stall; each result strobe is high for one cycle only.
`timescale 1ns / 1ps

module sorted_priority_queue_dup_detect
	import spq_pkg::*;
#(
	parameter int DEPTH    = 16,
	parameter int TAG_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  spq_cmd_t    cmd,
	output logic        done,
	output spq_result_t result
);

	localparam int SW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
	localparam int CW = $clog2(DEPTH + 1);

	logic              accept;
	logic              v_s1;
	spq_cmd_t          item_s1;
	logic [CW-1:0]     count_q;
	logic              dup_q;
	logic [SW-1:0]     dup_stored_q;
	logic [SW-1:0]     dup_new_q;
	logic [KEY_W-1:0]  dup_sev_q;
	logic              done_q;
	logic [2:0]        status_q;

	spq_key_t          cell_key [DEPTH];
	logic [SW-1:0]     cell_tag [DEPTH];
	logic [DEPTH-1:0]  ahead;
	logic [DEPTH-1:0]  match;

	spq_key_t          in_key;
	spq_key_t          new_key;
	logic [SW-1:0]     new_tag;
	spq_ctrl_t         ctrl;
	logic              any_match;
	logic [SW-1:0]     match_tag;
	logic              full;
	logic [2:0]        status_d;

	assign accept  = start && !busy;
	assign busy    = v_s1;
	assign in_key  = '{sev: cmd.severity, age: cmd.age};
	assign new_key = '{sev: item_s1.severity, age: item_s1.age};
	assign new_tag = item_s1.patient_tag[SW-1:0];
	assign full    = (count_q == CW'(DEPTH));

	// The row of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		spq_key_t      left_key;
		logic [SW-1:0] left_tag;
		logic          prev_ahead;
		spq_key_t      right_key;
		logic [SW-1:0] right_tag;

		if (i == 0) begin : g_first
			assign left_key   = '0;
			assign left_tag   = '0;
			assign prev_ahead = 1'b1;
		end else begin : g_inner
			assign left_key   = cell_key[i-1];
			assign left_tag   = cell_tag[i-1];
			assign prev_ahead = ahead[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_key = '0;
			assign right_tag = '0;
		end else begin : g_body
			assign right_key = cell_key[i+1];
			assign right_tag = cell_tag[i+1];
		end

		spq_cell #(
			.TW(SW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.eval      (accept),
			.key       (in_key),
			.occ       (count_q > CW'(i)),
			.ctrl      (ctrl),
			.new_key   (new_key),
			.new_tag   (new_tag),
			.prev_ahead(prev_ahead),
			.left_key  (left_key),
			.left_tag  (left_tag),
			.right_key (right_key),
			.right_tag (right_tag),
			.key_q     (cell_key[i]),
			.tag_q     (cell_tag[i]),
			.ahead_q   (ahead[i]),
			.match_q   (match[i])
		);
	end

	// Stored keys are unique, so at most one cell matches; collect its tag.
	always_comb begin
		match_tag = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) begin
				match_tag = match_tag | cell_tag[i];
			end
		end
		any_match = |match;
	end

	// Commit decision for the item held in the first stage.
	always_comb begin
		ctrl     = '0;
		status_d = ST_OK;
		if (item_s1.operation == OP_POP) begin
			if (count_q == '0) begin
				status_d = ST_EMPTY;
			end else begin
				ctrl.pop = v_s1;
			end
		end else if (dup_q) begin
			status_d = ST_IGNORED;
		end else if (any_match) begin
			status_d = ST_DUP;
		end else if (full) begin
			status_d = ST_FULL;
		end else begin
			ctrl.ins = v_s1;
		end
	end

	// Control state, occupancy and the duplicate record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= ST_OK;
			count_q      <= '0;
			dup_q        <= 1'b0;
			dup_stored_q <= '0;
			dup_new_q    <= '0;
			dup_sev_q    <= '0;
		end else begin
			v_s1   <= accept;
			done_q <= v_s1;
			if (v_s1) begin
				status_q <= status_d;
			end
			if (ctrl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.pop) begin
				count_q <= count_q - CW'(1);
			end
			if (v_s1 && status_d == ST_DUP) begin
				dup_q        <= 1'b1;
				dup_stored_q <= match_tag;
				dup_new_q    <= new_tag;
				dup_sev_q    <= item_s1.severity;
			end
		end
	end

	// The accepted item waits here while the cells compare.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= cmd;
		end
	end

	// Result drawn straight from the committed state.
	always_comb begin
		result                = '0;
		result.status         = status_q;
		result.head_valid     = (count_q != '0);
		if (count_q != '0) begin
			result.head_tag      = TAG_W'(cell_tag[0]);
			result.head_age      = cell_key[0].age;
			result.head_severity = cell_key[0].sev;
		end
		result.occupancy      = OCC_W'(count_q);
		result.dup_seen       = dup_q;
		result.dup_stored_tag = TAG_W'(dup_stored_q);
		result.dup_new_tag    = TAG_W'(dup_new_q);
		result.dup_severity   = dup_sev_q;
	end

	assign done = done_q;

`ifndef SYNTHESIS
	// A result never coincides with an item in flight.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while an item is in flight");

	// Every item in flight gives its result in the next cycle.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n) busy |=> done)
		else $error("item in flight gave no result");

	// Occupancy never exceeds the number of cells.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy above depth");

	// Stored keys are unique, so no more than one cell can match.
	a_match_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> $onehot0(match))
		else $error("more than one cell matched the key");

	// The duplicate flag is sticky.
	a_dup_sticky: assert property (@(posedge clk) disable iff (!arst_n) dup_q |=> dup_q)
		else $error("duplicate flag cleared");
`endif

endmodule
